### hdl/assert_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk once reset has been released.
`define TKSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also while reset is held.
`define TKSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Types and constants for the terminal key sequence decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

	localparam int MAX_HELD_BYTES_DEF = 32;
	localparam int FIFO_DEPTH         = 4;

	localparam logic [7:0] BYTE_ESC   = 8'h1b;
	localparam logic [7:0] BYTE_CR    = 8'h0d;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [7:0] BYTE_DEL   = 8'h7f;
	localparam logic [7:0] BYTE_BS    = 8'h08;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] CTRL_BIAS  = 8'h60; // 'a' - 1
	localparam logic [7:0] BYTE_TILDE = 8'h7e;
	localparam logic [7:0] BYTE_CSI   = 8'h5b; // '['
	localparam logic [7:0] BYTE_SS3   = 8'h4f; // 'O'
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_NINE  = 8'h39;
	localparam logic [7:0] BYTE_A     = 8'h41;
	localparam logic [7:0] BYTE_B     = 8'h42;
	localparam logic [7:0] BYTE_C     = 8'h43;
	localparam logic [7:0] BYTE_D     = 8'h44;
	localparam logic [7:0] BYTE_H     = 8'h48;
	localparam logic [7:0] BYTE_F     = 8'h46;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_INTRO  = 2'd2,
		MODE_DIGITS = 2'd3
	} decode_mode_t;

	typedef enum logic [3:0] {
		KIND_ENTER     = 4'd0,
		KIND_BACKSPACE = 4'd1,
		KIND_CHAR      = 4'd2,
		KIND_ESCAPE    = 4'd3,
		KIND_UP        = 4'd4,
		KIND_DOWN      = 4'd5,
		KIND_RIGHT     = 4'd6,
		KIND_LEFT      = 4'd7,
		KIND_HOME      = 4'd8,
		KIND_END       = 4'd9,
		KIND_PGUP      = 4'd10,
		KIND_PGDN      = 4'd11
	} key_kind_t;

	typedef struct packed {
		key_kind_t  kind;
		logic [7:0] char_code;
		logic       ctrl;
		logic       last;
	} key_word_t;

	// Up to two result words produced by one input byte.
	typedef struct packed {
		logic [1:0] n;
		key_word_t  w0;
		key_word_t  w1;
	} dec_out_t;

	function automatic key_word_t make_word(key_kind_t kind, logic [7:0] ch, logic ctrl);
		key_word_t w;
		w.kind      = kind;
		w.char_code = ch;
		w.ctrl      = ctrl;
		w.last      = 1'b0;
		return w;
	endfunction

endpackage

`default_nettype wire

### hdl/tksd_decode.sv
// ----------------------------------------------------------------------------
// tksd_decode
// Combinational next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tksd_decode import tksd_pkg::*; #(
	parameter int MAX_HELD_BYTES = MAX_HELD_BYTES_DEF,
	localparam int PEND_W = $clog2(MAX_HELD_BYTES + 1)
) (
	input  decode_mode_t      mode,
	input  logic [PEND_W-1:0] pend,
	input  logic [31:0]       value,
	input  logic [7:0]        in_byte,
	output decode_mode_t      mode_nx,
	output logic [PEND_W-1:0] pend_nx,
	output logic [31:0]       value_nx,
	output dec_out_t          dec
);

	decode_mode_t mode_eff;
	logic         is_digit;
	logic [31:0]  digit;
	key_word_t    alone_w;
	logic         alone_esc;

	// A sequence that has grown to the limit is thrown away first.
	assign mode_eff = (pend >= PEND_W'(MAX_HELD_BYTES)) ? MODE_IDLE : mode;
	assign is_digit = (in_byte >= BYTE_ZERO) && (in_byte <= BYTE_NINE);
	assign digit    = {28'd0, in_byte[3:0]};

	// Decoding of a byte on its own, outside any sequence.
	always_comb begin
		alone_esc = (in_byte == BYTE_ESC);
		if (in_byte == BYTE_CR || in_byte == BYTE_LF) begin
			alone_w = make_word(KIND_ENTER, 8'd0, 1'b0);
		end else if (in_byte == BYTE_DEL || in_byte == BYTE_BS) begin
			alone_w = make_word(KIND_BACKSPACE, 8'd0, 1'b0);
		end else if (in_byte < BYTE_SPACE) begin
			alone_w = make_word(KIND_CHAR, in_byte + CTRL_BIAS, 1'b1);
		end else begin
			alone_w = make_word(KIND_CHAR, in_byte, 1'b0);
		end
	end

	always_comb begin
		mode_nx  = MODE_IDLE;
		pend_nx  = '0;
		value_nx = '0;
		dec.n    = 2'd0;
		dec.w0   = make_word(KIND_ENTER, 8'd0, 1'b0);
		dec.w1   = make_word(KIND_ENTER, 8'd0, 1'b0);
		unique case (mode_eff)
			MODE_IDLE: begin
				if (alone_esc) begin
					mode_nx = MODE_ESC;
					pend_nx = PEND_W'(1);
				end else begin
					dec.n  = 2'd1;
					dec.w0 = alone_w;
				end
			end
			MODE_ESC: begin
				if (in_byte == BYTE_CSI || in_byte == BYTE_SS3) begin
					mode_nx  = MODE_INTRO;
					pend_nx  = PEND_W'(2);
					value_nx = value;
				end else begin
					dec.w0 = make_word(KIND_ESCAPE, 8'd0, 1'b0);
					if (alone_esc) begin
						dec.n   = 2'd1;
						mode_nx = MODE_ESC;
						pend_nx = PEND_W'(1);
					end else begin
						dec.n  = 2'd2;
						dec.w1 = alone_w;
					end
				end
			end
			MODE_INTRO: begin
				dec.n = 2'd1;
				priority if (in_byte == BYTE_A) begin
					dec.w0 = make_word(KIND_UP, 8'd0, 1'b0);
				end else if (in_byte == BYTE_B) begin
					dec.w0 = make_word(KIND_DOWN, 8'd0, 1'b0);
				end else if (in_byte == BYTE_C) begin
					dec.w0 = make_word(KIND_RIGHT, 8'd0, 1'b0);
				end else if (in_byte == BYTE_D) begin
					dec.w0 = make_word(KIND_LEFT, 8'd0, 1'b0);
				end else if (in_byte == BYTE_H) begin
					dec.w0 = make_word(KIND_HOME, 8'd0, 1'b0);
				end else if (in_byte == BYTE_F) begin
					dec.w0 = make_word(KIND_END, 8'd0, 1'b0);
				end else if (is_digit) begin
					dec.n    = 2'd0;
					mode_nx  = MODE_DIGITS;
					pend_nx  = PEND_W'(3);
					value_nx = digit;
				end else begin
					dec.n = 2'd0;
				end
			end
			MODE_DIGITS: begin
				if (is_digit) begin
					mode_nx  = MODE_DIGITS;
					pend_nx  = pend + PEND_W'(1);
					value_nx = (value << 3) + (value << 1) + digit;
				end else if (in_byte == BYTE_TILDE) begin
					dec.n = 2'd1;
					priority if (value == 32'd1 || value == 32'd7) begin
						dec.w0 = make_word(KIND_HOME, 8'd0, 1'b0);
					end else if (value == 32'd4 || value == 32'd8) begin
						dec.w0 = make_word(KIND_END, 8'd0, 1'b0);
					end else if (value == 32'd5) begin
						dec.w0 = make_word(KIND_PGUP, 8'd0, 1'b0);
					end else if (value == 32'd6) begin
						dec.w0 = make_word(KIND_PGDN, 8'd0, 1'b0);
					end else begin
						dec.n = 2'd0;
					end
				end
			end
		endcase
		// Mark the final word caused by this byte.
		if (dec.n == 2'd1) begin
			dec.w0.last = 1'b1;
		end
		if (dec.n == 2'd2) begin
			dec.w1.last = 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/tksd_out_fifo.sv
// ----------------------------------------------------------------------------
// tksd_out_fifo
// Small result queue that takes up to two words per cycle and gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tksd_out_fifo import tksd_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  dec_out_t  push,
	output logic      room,
	output key_word_t out_word,
	output logic      out_valid,
	input  wire       out_ready
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	key_word_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] tail;
	logic             pop;

	assign tail      = head_q + count_q[PTR_W-1:0];
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_word  = mem_q[head_q];
	// Room is judged before this cycle's pop so ready never depends on out_ready.
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[tail] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem_q[tail + PTR_W'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### hdl/terminal_key_sequence_decoder_core.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_core: VT100/xterm input key decoder.
// Results: words are written into the output queue when their byte is accepted and leave from its head in order.
// Throughput: one byte per cycle while the queue has room for two words; a byte giving two words fills two slots.
// Reset: asynchronous; decoder returns to idle and the output queue empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module terminal_key_sequence_decoder_core import tksd_pkg::*; #(
	parameter int MAX_HELD_BYTES = MAX_HELD_BYTES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] in_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [3:0] key_kind,
	output logic [7:0] key_char,
	output logic       ctrl_flag,
	output logic       last_flag
);

	localparam int PEND_W = $clog2(MAX_HELD_BYTES + 1);

	// Sequence state: where we are in an escape sequence, how many bytes the
	// sequence holds so far, and the decimal value of any digit run.
	decode_mode_t      mode_q;
	logic [PEND_W-1:0] pend_q;
	logic [31:0]       value_q;

	decode_mode_t      mode_nx;
	logic [PEND_W-1:0] pend_nx;
	logic [31:0]       value_nx;
	dec_out_t          dec;
	dec_out_t          push;
	key_word_t         out_word;
	logic              room;
	logic              in_acc;

	// The queue always keeps space for the two words one byte can produce,
	// so a byte is taken whenever two slots are free, even while the oldest
	// result still waits at the output.
	assign in_ready = room;
	assign in_acc   = in_valid && in_ready;

	// All the work for a byte is a single pass of short logic: the decoder
	// looks at the current state and the byte, and yields the next state and
	// zero, one or two words.
	tksd_decode #(
		.MAX_HELD_BYTES(MAX_HELD_BYTES)
	) u_decode (
		.mode    (mode_q),
		.pend    (pend_q),
		.value   (value_q),
		.in_byte (in_byte),
		.mode_nx (mode_nx),
		.pend_nx (pend_nx),
		.value_nx(value_nx),
		.dec     (dec)
	);

	// Only an accepted byte writes into the queue.
	always_comb begin
		push   = dec;
		push.n = in_acc ? dec.n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= '0;
			value_q <= '0;
		end else if (in_acc) begin
			mode_q  <= mode_nx;
			pend_q  <= pend_nx;
			value_q <= value_nx;
		end
	end

	// The queue is the result register: its head word drives the outputs.
	tksd_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_word (out_word),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	assign key_kind  = out_word.kind;
	assign key_char  = out_word.char_code;
	assign ctrl_flag = out_word.ctrl;
	assign last_flag = out_word.last;

	// Any sequence in progress holds at least the ESC byte.
	`TKSD_ASSERT(a_pend_nonzero, (mode_q != MODE_IDLE) |-> (pend_q != '0), "held sequence with zero count")
	// Idle means nothing is held and no digit value lingers.
	`TKSD_ASSERT_ALWAYS(a_idle_clean, (mode_q == MODE_IDLE) |-> (pend_q == '0 && value_q == '0), "idle state not clean")
	// The held count never passes the limit.
	`TKSD_ASSERT(a_pend_limit, pend_q <= PEND_W'(MAX_HELD_BYTES), "held count beyond limit")
	// A byte that produces words always makes the output valid next cycle.
	`TKSD_ASSERT(a_out_follows, (in_acc && dec.n != 2'd0) |=> out_valid, "produced word not presented")

endmodule

`default_nettype wire
